// ===== rtl/kcl_pkg.sv =====
// kcl_pkg: shared types, character codes and the control store for the
// keyboard command line decoder. No dependencies.
`timescale 1ns / 1ps

package kcl_pkg;

    localparam int KEY_W      = 8;
    localparam int KIND_W     = 3;
    localparam int NUM_W      = 8;
    localparam int SPD_W      = 4;
    localparam int LEN_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int VAL_W      = 16;
    localparam int UPC_W      = 3;

    localparam logic [KEY_W-1:0] KEY_RETURN = 8'd13;
    localparam logic [KEY_W-1:0] KEY_BACK   = 8'd8;
    localparam logic [KEY_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [KEY_W-1:0] CH_0       = 8'h30;
    localparam logic [KEY_W-1:0] CH_9       = 8'h39;
    localparam logic [KEY_W-1:0] CH_Q       = 8'h71;
    localparam logic [KEY_W-1:0] CH_T       = 8'h74;
    localparam logic [KEY_W-1:0] CH_R       = 8'h72;
    localparam logic [KEY_W-1:0] CH_S       = 8'h73;
    localparam logic [KEY_W-1:0] CH_UPPER_S = 8'h53;
    localparam logic [KEY_W-1:0] CH_UPPER_C = 8'h43;

    localparam int               ARG_START     = 3;
    localparam logic [VAL_W-1:0] VAL_SAT       = 16'hFFFF;
    localparam logic [VAL_W-1:0] SW_LOW_END    = 16'd19;
    localparam logic [VAL_W-1:0] SW_HIGH_START = 16'h98;
    localparam logic [VAL_W-1:0] SW_HIGH_END   = 16'h9D;

    localparam logic [NUM_W-1:0] TRAIN_LIMIT_RST = 8'd80;
    localparam logic [SPD_W-1:0] SPEED_LIMIT_RST = 4'd14;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE    = 3'd0,
        KIND_SPEED   = 3'd1,
        KIND_REVERSE = 3'd2,
        KIND_SWITCH  = 3'd3,
        KIND_QUIT    = 3'd4
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRAIN_LIMIT = 1'b0,
        REG_SPEED_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INIT,
        OP_FIRST,
        OP_SCAN,
        OP_EVAL,
        OP_EDIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_NOT_EXEC,
        C_PRESENT,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic             in_rdy;
        op_t              op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic exec_line;
        logic present;
        logic out_busy;
    } stat_t;

    typedef struct packed {
        kind_t            kind;
        logic [NUM_W-1:0] target;
        logic [SPD_W-1:0] speed;
        logic             curved;
        logic [LEN_W-1:0] len;
    } res_t;

    // control store addresses
    localparam logic [UPC_W-1:0] UA_IDLE     = 3'd0;
    localparam logic [UPC_W-1:0] UA_DISPATCH = 3'd1;
    localparam logic [UPC_W-1:0] UA_INIT     = 3'd2;
    localparam logic [UPC_W-1:0] UA_FIRST    = 3'd3;
    localparam logic [UPC_W-1:0] UA_SCAN     = 3'd4;
    localparam logic [UPC_W-1:0] UA_EVAL     = 3'd5;
    localparam logic [UPC_W-1:0] UA_BACK     = 3'd6;
    localparam logic [UPC_W-1:0] UA_EDIT     = 3'd7;

    // jump taken when cond holds, else fall through (the edit word wraps to idle)
    function automatic ctrl_t ucode(input logic [UPC_W-1:0] addr);
        ctrl_t w;
        w = '{in_rdy: 1'b0, op: OP_NONE, cond: C_NEVER, target: UA_IDLE};
        case (addr)
            UA_IDLE:     w = '{in_rdy: 1'b1, op: OP_NONE,  cond: C_NO_IN,    target: UA_IDLE};
            UA_DISPATCH: w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_NOT_EXEC, target: UA_EDIT};
            UA_INIT:     w = '{in_rdy: 1'b0, op: OP_INIT,  cond: C_NEVER,    target: UA_IDLE};
            UA_FIRST:    w = '{in_rdy: 1'b0, op: OP_FIRST, cond: C_NEVER,    target: UA_IDLE};
            UA_SCAN:     w = '{in_rdy: 1'b0, op: OP_SCAN,  cond: C_PRESENT,  target: UA_SCAN};
            UA_EVAL:     w = '{in_rdy: 1'b0, op: OP_EVAL,  cond: C_OUT_BUSY, target: UA_EVAL};
            UA_BACK:     w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: UA_IDLE};
            UA_EDIT:     w = '{in_rdy: 1'b0, op: OP_EDIT,  cond: C_OUT_BUSY, target: UA_EDIT};
            default:     w = '{in_rdy: 1'b0, op: OP_NONE,  cond: C_ALWAYS,   target: UA_IDLE};
        endcase
        return w;
    endfunction

    // value*10 + digit, saturating; the digit is the low nibble of an ASCII digit
    function automatic logic [VAL_W-1:0] dec_step(input logic [VAL_W-1:0] v,
                                                 input logic [KEY_W-1:0] c);
        logic [VAL_W+3:0] t;
        t = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {{VAL_W{1'b0}}, c[3:0]};
        return (t > {4'b0, VAL_SAT}) ? VAL_SAT : t[VAL_W-1:0];
    endfunction

endpackage

// ===== rtl/kcl_if.sv =====
// kcl_key_if / kcl_res_if: valid-ready channels for key bytes and results.
// Depends on kcl_pkg for field widths.
`timescale 1ns / 1ps

interface kcl_key_if import kcl_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] key_byte;

    modport source (output valid, output key_byte, input ready);
    modport sink (input valid, input key_byte, output ready);
endinterface

interface kcl_res_if import kcl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] command_kind;
    logic [NUM_W-1:0]  target_number;
    logic [SPD_W-1:0]  speed_value;
    logic              switch_curved;
    logic [LEN_W-1:0]  line_length;

    modport source (output valid, output command_kind, output target_number,
                    output speed_value, output switch_curved, output line_length,
                    input ready);
    modport sink (input valid, input command_kind, input target_number,
                  input speed_value, input switch_curved, input line_length,
                  output ready);
endinterface

// ===== rtl/kcl_ram.sv =====
// kcl_ram: generic simple dual-port RAM, one write port, one registered read.
// No dependencies.
`timescale 1ns / 1ps

module kcl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/kcl_useq.sv =====
// kcl_useq: step counter and control store with conditional jumps.
// Depends on kcl_pkg (ctrl_t, stat_t, ucode).
`timescale 1ns / 1ps

module kcl_useq import kcl_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  stat_t stat,
    output ctrl_t ctrl
);

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic             jump;

    assign ctrl = ucode(upc_reg);

    always_comb
    begin
        case (ctrl.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_IN:    jump = !stat.in_valid;
            C_NOT_EXEC: jump = !stat.exec_line;
            C_PRESENT:  jump = stat.present;
            C_OUT_BUSY: jump = stat.out_busy;
            default:    jump = 1'b0;
        endcase
        upc_next = jump ? ctrl.target : upc_reg + UPC_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== rtl/kcl_dp.sv =====
// kcl_dp: line buffer, scan pointer and argument parser driven by the
// sequencer op. Depends on kcl_pkg and kcl_ram.
`timescale 1ns / 1ps

module kcl_dp import kcl_pkg::*; #(
    parameter int LINE_DEPTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  op_t              op,
    input  logic             in_fire,
    input  logic [KEY_W-1:0] key_byte,
    input  logic             go,
    input  logic [NUM_W-1:0] train_limit,
    input  logic [SPD_W-1:0] speed_limit,
    output logic             present,
    output logic             exec_line,
    output logic             res_load,
    output res_t             res
);

    localparam int IDX_W = $clog2(LINE_DEPTH);
    localparam int CNT_W = $clog2(LINE_DEPTH + 1);

    logic [KEY_W-1:0] key_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [KEY_W-1:0] first_reg, first_next;
    logic [VAL_W-1:0] num_reg, num_next;
    logic             num_act_reg, num_act_next;
    logic [VAL_W-1:0] spd_reg, spd_next;
    logic             spd_act_reg, spd_act_next;
    logic             sp_found_reg, sp_found_next;
    logic             dir_pend_reg, dir_pend_next;
    logic             dir_ok_reg, dir_ok_next;
    logic [KEY_W-1:0] dir_reg, dir_next;

    logic             ram_we;
    logic [KEY_W-1:0] c;
    logic             is_digit;
    logic             train_ok, speed_ok, dir_sc, switch_ok;
    logic [CNT_W+LEN_W-1:0] len_ext;

    kcl_ram #(
        .WIDTH (KEY_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (key_reg),
        .raddr (pos_next[IDX_W-1:0]),
        .rdata (c)
    );

    // read data always belongs to pos_reg: the address is taken from pos_next
    assign present   = pos_reg < count_reg;
    assign exec_line = (key_reg == KEY_RETURN) && (count_reg != '0);
    assign is_digit  = c inside {[CH_0:CH_9]};

    assign train_ok  = (num_reg != '0) && (num_reg <= {{(VAL_W-NUM_W){1'b0}}, train_limit});
    assign speed_ok  = spd_reg <= {{(VAL_W-SPD_W){1'b0}}, speed_limit};
    assign dir_sc    = dir_ok_reg && ((dir_reg == CH_UPPER_S) || (dir_reg == CH_UPPER_C));
    assign switch_ok = ((num_reg != '0) && (num_reg < SW_LOW_END))
                    || ((num_reg > SW_HIGH_START) && (num_reg < SW_HIGH_END));

    always_comb
    begin
        count_next    = count_reg;
        pos_next      = pos_reg;
        first_next    = first_reg;
        num_next      = num_reg;
        num_act_next  = num_act_reg;
        spd_next      = spd_reg;
        spd_act_next  = spd_act_reg;
        sp_found_next = sp_found_reg;
        dir_pend_next = dir_pend_reg;
        dir_ok_next   = dir_ok_reg;
        dir_next      = dir_reg;
        ram_we        = 1'b0;
        res_load      = 1'b0;
        res.kind      = KIND_NONE;
        res.target    = '0;
        res.speed     = '0;
        res.curved    = 1'b0;

        case (op)
            OP_INIT:
            begin
                pos_next      = '0;
                num_next      = '0;
                num_act_next  = 1'b1;
                spd_next      = '0;
                spd_act_next  = 1'b0;
                sp_found_next = 1'b0;
                dir_pend_next = 1'b0;
                dir_ok_next   = 1'b0;
            end
            OP_FIRST:
            begin
                first_next = c;
                pos_next   = CNT_W'(ARG_START);
            end
            OP_SCAN:
            begin
                if (present)
                begin
                    pos_next = pos_reg + CNT_W'(1);
                    if (num_act_reg)
                    begin
                        if (is_digit)
                        begin
                            num_next = dec_step(num_reg, c);
                        end
                        else
                        begin
                            num_act_next = 1'b0;
                        end
                    end
                    // speed digits start one past the space
                    if (spd_act_reg)
                    begin
                        if (is_digit)
                        begin
                            spd_next = dec_step(spd_reg, c);
                        end
                        else
                        begin
                            spd_act_next = 1'b0;
                        end
                    end
                    if (dir_pend_reg)
                    begin
                        dir_next      = c;
                        dir_ok_next   = 1'b1;
                        dir_pend_next = 1'b0;
                    end
                    if (!sp_found_reg && (c == CH_SPACE))
                    begin
                        sp_found_next = 1'b1;
                        spd_act_next  = 1'b1;
                        dir_pend_next = 1'b1;
                    end
                end
            end
            OP_EVAL:
            begin
                if (go)
                begin
                    res_load   = 1'b1;
                    count_next = '0;
                    case (first_reg)
                        CH_Q:
                        begin
                            res.kind = KIND_QUIT;
                        end
                        CH_T:
                        begin
                            if (sp_found_reg && train_ok && speed_ok)
                            begin
                                res.kind   = KIND_SPEED;
                                res.target = num_reg[NUM_W-1:0];
                                res.speed  = spd_reg[SPD_W-1:0];
                            end
                        end
                        CH_R:
                        begin
                            if (train_ok)
                            begin
                                res.kind   = KIND_REVERSE;
                                res.target = num_reg[NUM_W-1:0];
                            end
                        end
                        CH_S:
                        begin
                            if (sp_found_reg && dir_sc && switch_ok)
                            begin
                                res.kind   = KIND_SWITCH;
                                res.target = num_reg[NUM_W-1:0];
                                res.curved = (dir_reg == CH_UPPER_C);
                            end
                        end
                        default:
                        begin
                            res.kind = KIND_NONE;
                        end
                    endcase
                end
            end
            OP_EDIT:
            begin
                if (go)
                begin
                    res_load = 1'b1;
                    if (key_reg == KEY_BACK)
                    begin
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                    else if (key_reg != KEY_RETURN)
                    begin
                        // full line drops the byte
                        if (count_reg < CNT_W'(LINE_DEPTH))
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase

        len_ext = {{LEN_W{1'b0}}, count_next};
        res.len = len_ext[LEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            key_reg <= key_byte;
        end
        first_reg <= first_next;
        num_reg   <= num_next;
        spd_reg   <= spd_next;
        dir_reg   <= dir_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            pos_reg      <= '0;
            num_act_reg  <= 1'b0;
            spd_act_reg  <= 1'b0;
            sp_found_reg <= 1'b0;
            dir_pend_reg <= 1'b0;
            dir_ok_reg   <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            pos_reg      <= pos_next;
            num_act_reg  <= num_act_next;
            spd_act_reg  <= spd_act_next;
            sp_found_reg <= sp_found_next;
            dir_pend_reg <= dir_pend_next;
            dir_ok_reg   <= dir_ok_next;
        end
    end

endmodule

// ===== rtl/keyboard_command_line_decoder.sv =====
// Keyboard command line decoder: one result per key byte, one key in flight.
// Edit keys (store, backspace, return on empty line) go idle, dispatch, edit; the edit step
// loads the result and the sequencer wraps to idle for the next key. Return on a non-empty
// line goes idle, dispatch, init, first, scan, evaluate, back; the scan reads one char per cycle.
// A waiting result stalls the edit/evaluate step while the output is held off.
// Reset clears the line count and restores the limits; the line RAM is not cleared.
`timescale 1ns / 1ps

module keyboard_command_line_decoder import kcl_pkg::*; #(
    parameter int LINE_DEPTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    kcl_key_if.sink               key_in,
    kcl_res_if.source             res_out
);

    logic [NUM_W-1:0] train_limit_reg, train_limit_next;
    logic [SPD_W-1:0] speed_limit_reg, speed_limit_next;
    logic             out_valid_reg, out_valid_next;
    res_t             res_reg;

    ctrl_t ctrl;
    stat_t stat;
    res_t  res;
    logic  in_fire, out_busy, present, exec_line, res_load;

    assign in_fire      = key_in.valid && key_in.ready;
    assign key_in.ready = ctrl.in_rdy;
    assign out_busy     = out_valid_reg && !res_out.ready;

    assign stat.in_valid  = key_in.valid;
    assign stat.exec_line = exec_line;
    assign stat.present   = present;
    assign stat.out_busy  = out_busy;

    kcl_useq u_useq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    kcl_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (ctrl.op),
        .in_fire     (in_fire),
        .key_byte    (key_in.key_byte),
        .go          (!out_busy),
        .train_limit (train_limit_reg),
        .speed_limit (speed_limit_reg),
        .present     (present),
        .exec_line   (exec_line),
        .res_load    (res_load),
        .res         (res)
    );

    always_comb
    begin
        train_limit_next = train_limit_reg;
        speed_limit_next = speed_limit_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_TRAIN_LIMIT: train_limit_next = cfg_data[NUM_W-1:0];
                REG_SPEED_LIMIT: speed_limit_next = cfg_data[SPD_W-1:0];
                default:         train_limit_next = train_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            train_limit_reg <= TRAIN_LIMIT_RST;
            speed_limit_reg <= SPEED_LIMIT_RST;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            train_limit_reg <= train_limit_next;
            speed_limit_reg <= speed_limit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res;
        end
    end

    assign res_out.valid         = out_valid_reg;
    assign res_out.command_kind  = res_reg.kind;
    assign res_out.target_number = res_reg.target;
    assign res_out.speed_value   = res_reg.speed;
    assign res_out.switch_curved = res_reg.curved;
    assign res_out.line_length   = res_reg.len;

    // a new result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (!out_valid_reg || res_out.ready))
        else $error("result loaded over a pending result");

    // the sequencer leaves the idle word right after a key transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !key_in.ready)
        else $error("second key taken before the first finished");

    // an issued command always clears the line
    a_cmd_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res.kind != KIND_NONE)) |-> (res.len == '0))
        else $error("command issued without clearing the line");

    // an issued speed never exceeds the configured limit
    a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (res_load && (res.kind == KIND_SPEED)) |-> (res.speed <= speed_limit_reg))
        else $error("speed command above limit");

endmodule

// ===== tb/keyboard_command_line_decoder_tb.sv =====
// Self-checking testbench for keyboard_command_line_decoder: a directed key table, then
// random command lines under several limit settings; results checked against table or model.
// Depends on kcl_pkg and the kcl_key_if / kcl_res_if channel interfaces.
`timescale 1ns / 1ps

module keyboard_command_line_decoder_tb;
    import kcl_pkg::*;

    localparam int DEPTH       = 32;
    localparam int LIMIT       = 500000;
    localparam int SETTLE      = 50;
    localparam int HOLD_CYCLES = 250;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             typed;
        res_t             want;
    } key_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kcl_key_if key_ch ();
    kcl_res_if res_ch ();

    keyboard_command_line_decoder #(.LINE_DEPTH(DEPTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_in    (key_ch),
        .res_out   (res_ch)
    );

    always #6 clk = ~clk;

    // model state
    logic [KEY_W-1:0] line_buf [DEPTH];
    int unsigned      line_cnt;
    logic [NUM_W-1:0] train_lim;
    logic [SPD_W-1:0] speed_lim;

    res_t             expected_commands [$];
    logic [KEY_W-1:0] line_keys [$];
    int               mismatches = 0;
    int               cycles = 0;
    bit               idle_on = 1'b0;
    bit               phase_idle = 1'b1;
    bit               hold_req = 1'b0;

    function automatic int unsigned parse_number(int unsigned start);
        int unsigned val;
        int unsigned p;
        val = 0;
        p = start;
        while (p < line_cnt && line_buf[p] >= CH_0 && line_buf[p] <= CH_9) begin
            val = val * 10 + (line_buf[p] - CH_0);
            if (val > VAL_SAT)
                val = VAL_SAT;
            p++;
        end
        return val;
    endfunction

    function automatic bit find_space(output int unsigned where);
        for (int unsigned p = ARG_START; p < line_cnt; p++) begin
            if (line_buf[p] == CH_SPACE) begin
                where = p;
                return 1'b1;
            end
        end
        where = 0;
        return 1'b0;
    endfunction

    function automatic res_t decode_key(logic [KEY_W-1:0] k);
        res_t        r;
        int unsigned sp;
        int unsigned num;
        int unsigned spd;
        logic [KEY_W-1:0] lead_ch;
        logic [KEY_W-1:0] dir;
        r = '{kind: KIND_NONE, target: '0, speed: '0, curved: 1'b0, len: '0};
        if (k == KEY_RETURN) begin
            if (line_cnt != 0) begin
                lead_ch = line_buf[0];
                if (lead_ch == CH_Q) begin
                    r.kind = KIND_QUIT;
                end else if (lead_ch == CH_T) begin
                    if (find_space(sp)) begin
                        num = parse_number(ARG_START);
                        spd = parse_number(sp + 1);
                        if (num >= 1 && num <= train_lim && spd <= speed_lim) begin
                            r.kind   = KIND_SPEED;
                            r.target = NUM_W'(num);
                            r.speed  = SPD_W'(spd);
                        end
                    end
                end else if (lead_ch == CH_R) begin
                    num = parse_number(ARG_START);
                    if (num >= 1 && num <= train_lim) begin
                        r.kind   = KIND_REVERSE;
                        r.target = NUM_W'(num);
                    end
                end else if (lead_ch == CH_S) begin
                    if (find_space(sp) && sp + 1 < line_cnt) begin
                        num = parse_number(ARG_START);
                        dir = line_buf[sp + 1];
                        if ((dir == CH_UPPER_S || dir == CH_UPPER_C) &&
                            ((num > 0 && num < SW_LOW_END) ||
                             (num > SW_HIGH_START && num < SW_HIGH_END))) begin
                            r.kind   = KIND_SWITCH;
                            r.target = NUM_W'(num);
                            r.curved = (dir == CH_UPPER_C);
                        end
                    end
                end
                line_cnt = 0;
            end
        end else if (k == KEY_BACK) begin
            if (line_cnt != 0)
                line_cnt--;
        end else if (line_cnt < DEPTH) begin
            line_buf[line_cnt] = k;
            line_cnt++;
        end
        r.len = LEN_W'(line_cnt);
        return r;
    endfunction

    function automatic key_row_t key_row(logic [KEY_W-1:0] k, bit typed, kind_t kd,
                                         logic [LEN_W-1:0] len);
        key_row_t row;
        row.key   = k;
        row.typed = typed;
        row.want  = '{kind: kd, target: '0, speed: '0, curved: 1'b0, len: len};
        return row;
    endfunction

    function automatic logic [KEY_W-1:0] printable();
        return KEY_W'($urandom_range(32, 126));
    endfunction

    function automatic void push_number(longint v);
        string s;
        if (v < 0)
            return;
        if ($urandom_range(0, 7) == 0)
            line_keys.push_back(CH_0);
        s = $sformatf("%0d", v);
        foreach (s[i])
            line_keys.push_back(s[i]);
    endfunction

    function automatic longint pick_number();
        case ($urandom_range(0, 6))
            0: return -1;
            1: return $urandom_range(0, 20);
            2: return longint'(train_lim) - 1 + $urandom_range(0, 2);
            3: return $urandom_range(150, 158);
            4: return $urandom_range(0, 255);
            5: return 65536 + $urandom_range(0, 80);
            default: return longint'($urandom);
        endcase
    endfunction

    function automatic longint pick_speed();
        case ($urandom_range(0, 4))
            0: return -1;
            1: return longint'(speed_lim) + $urandom_range(0, 1);
            2: return 65536 + $urandom_range(0, 15);
            default: return $urandom_range(0, 17);
        endcase
    endfunction

    // one command line, mostly well formed, ending in return
    function automatic void build_line();
        int mode;
        int n;
        int at;
        logic [KEY_W-1:0] cmd;
        line_keys.delete();
        mode = $urandom_range(0, 9);
        if (mode == 9) begin
            n = $urandom_range(1, 40);
            repeat (n) line_keys.push_back(KEY_W'($urandom_range(0, 255)));
        end else begin
            case ($urandom_range(0, 3))
                0: cmd = CH_T;
                1: cmd = CH_R;
                2: cmd = CH_S;
                default: cmd = CH_Q;
            endcase
            line_keys.push_back(cmd);
            // positions 1 and 2 are not parsed
            repeat (2) line_keys.push_back(($urandom_range(0, 3) == 0) ? printable() : CH_SPACE);
            if ($urandom_range(0, 9) == 0)
                line_keys.push_back(printable());
            push_number(pick_number());
            if ((cmd == CH_T || cmd == CH_S) && $urandom_range(0, 9) != 0)
                line_keys.push_back(CH_SPACE);
            if (cmd == CH_T)
                push_number(pick_speed());
            if (cmd == CH_S) begin
                case ($urandom_range(0, 5))
                    0: ;
                    1: line_keys.push_back(printable());
                    2, 3: line_keys.push_back(CH_UPPER_S);
                    default: line_keys.push_back(CH_UPPER_C);
                endcase
            end
            if (mode == 8)
                repeat ($urandom_range(20, 40)) line_keys.push_back(printable());
            if ($urandom_range(0, 9) == 0) begin
                n = $urandom_range(1, 3);
                while (line_keys.size() > n)
                    void'(line_keys.pop_back());
            end
            if ($urandom_range(0, 6) == 0) begin
                at = $urandom_range(1, line_keys.size());
                line_keys.insert(at, printable());
                line_keys.insert(at + 1, KEY_BACK);
            end
        end
        line_keys.push_back(KEY_RETURN);
    endfunction

    task automatic send_key(input logic [KEY_W-1:0] k, input bit typed, input res_t want);
        int gap;
        res_t predicted;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            key_ch.valid <= 1'b0;
        end
        @(negedge clk);
        key_ch.valid    <= 1'b1;
        key_ch.key_byte <= k;
        do @(posedge clk); while (!(key_ch.valid && key_ch.ready));
        predicted = decode_key(k);
        expected_commands.push_back(typed ? want : predicted);
    endtask

    task automatic run_random(input int keys, input int hold_at);
        int sent;
        sent = 0;
        while (sent < keys)
        begin
            build_line();
            idle_on = phase_idle && ($urandom_range(0, 4) != 0);
            foreach (line_keys[i])
            begin
                if (sent == hold_at)
                    hold_req = 1'b1;
                send_key(line_keys[i], 1'b0, '0);
                sent++;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        key_ch.valid <= 1'b0;
        while (expected_commands.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_limits(input logic [NUM_W-1:0] train, input logic [CFG_DATA_W-1:0] spd);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TRAIN_LIMIT;
        cfg_data  <= train;
        @(negedge clk);
        cfg_index <= REG_SPEED_LIMIT;
        cfg_data  <= spd;
        @(negedge clk);
        cfg_we <= 1'b0;
        train_lim = train;
        speed_lim = spd[SPD_W-1:0];
    endtask

    task automatic flag_field(input string name, input int unsigned want, input int unsigned got);
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_commands.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d len %0d",
                         $time, res_ch.command_kind, res_ch.line_length);
            end else begin
                want = expected_commands.pop_front();
                if (res_ch.command_kind !== want.kind)
                    flag_field("command_kind", want.kind, res_ch.command_kind);
                if (res_ch.target_number !== want.target)
                    flag_field("target_number", want.target, res_ch.target_number);
                if (res_ch.speed_value !== want.speed)
                    flag_field("speed_value", want.speed, res_ch.speed_value);
                if (res_ch.switch_curved !== want.curved)
                    flag_field("switch_curved", want.curved, res_ch.switch_curved);
                if (res_ch.line_length !== want.len)
                    flag_field("line_length", want.len, res_ch.line_length);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin : result_sink
        int n;
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req) begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                res_ch.ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        key_row_t rows [$];
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_TRAIN_LIMIT;
        cfg_data        = '0;
        key_ch.valid    = 1'b0;
        key_ch.key_byte = '0;
        line_cnt        = 0;
        train_lim       = TRAIN_LIMIT_RST;
        speed_lim       = SPEED_LIMIT_RST;
        foreach (line_buf[i])
            line_buf[i] = '0;

        rows = '{
            // empty line: return and backspace do nothing
            key_row(KEY_RETURN, 1'b1, KIND_NONE, 6'd0),
            key_row(KEY_BACK,   1'b1, KIND_NONE, 6'd0),
            // byte extremes, edit, unknown first char
            key_row(8'h00,      1'b1, KIND_NONE, 6'd1),
            key_row(8'hFF,      1'b1, KIND_NONE, 6'd2),
            key_row(KEY_BACK,   1'b1, KIND_NONE, 6'd1),
            key_row(KEY_RETURN, 1'b1, KIND_NONE, 6'd0),
            key_row(CH_Q,       1'b1, KIND_NONE, 6'd1),
            key_row(KEY_RETURN, 1'b1, KIND_QUIT, 6'd0),
            // "r  5"
            key_row(CH_R, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row("5", 1'b0, KIND_NONE, 6'd0),
            key_row(KEY_RETURN, 1'b0, KIND_NONE, 6'd0),
            // "t  1 9"
            key_row(CH_T, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row("1", 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row("9", 1'b0, KIND_NONE, 6'd0),
            key_row(KEY_RETURN, 1'b0, KIND_NONE, 6'd0),
            // "s  9 C"
            key_row(CH_S, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row("9", 1'b0, KIND_NONE, 6'd0),
            key_row(CH_SPACE, 1'b0, KIND_NONE, 6'd0),
            key_row(CH_UPPER_C, 1'b0, KIND_NONE, 6'd0),
            key_row(KEY_RETURN, 1'b0, KIND_NONE, 6'd0)
        };

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits
        idle_on = 1'b1;
        foreach (rows[i])
            send_key(rows[i].key, rows[i].typed, rows[i].want);
        run_random(250, -1);
        drain();

        // train limit 0 rejects all trains; speed write masked to 15
        write_limits(8'd0, 8'hFF);
        run_random(200, 60);
        drain();

        write_limits(8'd1, 8'h00);
        run_random(250, -1);
        drain();

        write_limits(8'd255, 8'hF7);
        run_random(250, -1);
        drain();

        // closing stretch without stalls on either side
        phase_idle = 1'b0;
        write_limits(8'd12, 8'h0F);
        run_random(300, -1);
        drain();

        if (expected_commands.size() != 0) begin
            mismatches++;
            $display("%0t: %0d results never arrived", $time, expected_commands.size());
        end
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
